[sv/llsp_pkg.sv]
`default_nettype none

package llsp_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned TYPE_W = 16;
  localparam int unsigned LOAD_W = 16;
  localparam int unsigned SOCK_W = 32;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_SELECT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_MATCH = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  // item traveling down the row of cells
  typedef struct packed {
    logic               active;
    cmd_e               cmd;
    logic [ID_W-1:0]    id;
    logic [TYPE_W-1:0]  srv_type;
    logic [LOAD_W-1:0]  load;
    logic [SOCK_W-1:0]  sock;
    logic [TYPE_W-1:0]  want;
    logic               hit;
    logic               free_ok;
    logic [IDX_W-1:0]   free_idx;
    logic               best_ok;
    logic [IDX_W-1:0]   best_idx;
    logic [ID_W-1:0]    best_id;
    logic [TYPE_W-1:0]  best_type;
    logic [LOAD_W-1:0]  best_load;
    logic [SOCK_W-1:0]  best_sock;
  } probe_t;

  // write-back to one cell once the scan is over
  typedef struct packed {
    logic               en;
    cmd_e               op;
    logic [IDX_W-1:0]   idx;
    logic [ID_W-1:0]    id;
    logic [TYPE_W-1:0]  srv_type;
    logic [LOAD_W-1:0]  load;
    logic [SOCK_W-1:0]  sock;
  } commit_t;

  function automatic logic [LOAD_W-1:0] sat_inc(input logic [LOAD_W-1:0] val);
    logic [LOAD_W-1:0] res;
    res = (val == {LOAD_W{1'b1}}) ? val : val + LOAD_W'(1);
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/llsp_cell.sv]
`default_nettype none

module llsp_cell
  import llsp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] my_idx_i,
  input  wire probe_t           probe_i,
  input  wire commit_t          commit_i,
  output probe_t                probe_o
);

  logic              valid_q;
  logic [ID_W-1:0]   id_q;
  logic [TYPE_W-1:0] type_q;
  logic [LOAD_W-1:0] load_q;
  logic [SOCK_W-1:0] sock_q;

  probe_t            probe_d;
  probe_t            probe_q;
  logic              upd_hit;
  logic              sel_match;
  logic              sel_better;
  logic              commit_me;

  assign upd_hit = probe_i.active && (probe_i.cmd == CMD_UPDATE) && valid_q &&
                   (id_q == probe_i.id);
  assign sel_match = probe_i.active && (probe_i.cmd == CMD_SELECT) && valid_q &&
                     ((type_q & probe_i.want) != '0);
  assign sel_better = !probe_i.best_ok || (load_q < probe_i.best_load) ||
                      ((load_q == probe_i.best_load) && (id_q < probe_i.best_id));
  assign commit_me = commit_i.en && (commit_i.idx == my_idx_i);

  always_comb begin
    probe_d = probe_i;
    if (upd_hit) begin
      probe_d.hit = 1'b1;
    end
    if (probe_i.active && (probe_i.cmd == CMD_UPDATE) && !valid_q && !probe_i.free_ok) begin
      probe_d.free_ok  = 1'b1;
      probe_d.free_idx = my_idx_i;
    end
    if (sel_match && sel_better) begin
      probe_d.best_ok   = 1'b1;
      probe_d.best_idx  = my_idx_i;
      probe_d.best_id   = id_q;
      probe_d.best_type = type_q;
      probe_d.best_load = load_q;
      probe_d.best_sock = sock_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
      valid_q <= 1'b0;
    end else begin
      probe_q <= probe_d;
      if (commit_me && (commit_i.op == CMD_UPDATE)) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_hit) begin
      load_q <= probe_i.load;
      sock_q <= probe_i.sock;
    end else if (commit_me) begin
      unique case (commit_i.op)
        CMD_UPDATE: begin
          id_q   <= commit_i.id;
          type_q <= commit_i.srv_type;
          load_q <= commit_i.load;
          sock_q <= commit_i.sock;
        end
        CMD_SELECT: begin
          load_q <= sat_inc(load_q);
        end
        default: begin
          load_q <= load_q;
        end
      endcase
    end
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire

[sv/least_loaded_server_picker_core.sv]
// Server table of TABLE_ENTRIES cells with least-loaded pick. Raise start_i while
// busy_o is low to hand in one item; the item is registered at the head, then walks
// the row of cells through the register of each cell in turn, and at the last cell
// the chosen entry is written back while the result is registered. One item is in
// flight at a time. The result shows on the output ports for exactly one cycle
// with done_o high and cannot be held off, so capture it then. busy_o drops in
// that same cycle, and a new start_i may be given at once.
`default_nettype none

module least_loaded_server_picker_core
  import llsp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic              command_i,
  input  wire logic [ID_W-1:0]   server_id_i,
  input  wire logic [TYPE_W-1:0] server_type_i,
  input  wire logic [LOAD_W-1:0] load_count_i,
  input  wire logic [SOCK_W-1:0] socket_number_i,
  input  wire logic [TYPE_W-1:0] wanted_type_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [ID_W-1:0]        chosen_id_o,
  output logic [TYPE_W-1:0]      chosen_type_o,
  output logic [LOAD_W-1:0]      chosen_load_o,
  output logic [SOCK_W-1:0]      chosen_socket_o
);

  probe_t            probe [TABLE_ENTRIES+1];
  probe_t            head_d;
  probe_t            head_q;
  probe_t            tail;
  commit_t           commit;
  logic              accept;
  logic              busy_q;
  logic              done_q;
  status_e           status_q;
  status_e           status_d;
  logic [ID_W-1:0]   id_q;
  logic [TYPE_W-1:0] type_q;
  logic [LOAD_W-1:0] load_q;
  logic [SOCK_W-1:0] sock_q;
  logic [LOAD_W-1:0] new_load;

  assign accept = start_i && !busy_q;

  always_comb begin
    head_d          = '0;
    head_d.active   = accept;
    head_d.cmd      = cmd_e'(command_i);
    head_d.id       = server_id_i;
    head_d.srv_type = server_type_i;
    head_d.load     = load_count_i;
    head_d.sock     = socket_number_i;
    head_d.want     = wanted_type_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  assign probe[0] = head_q;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    llsp_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .my_idx_i (IDX_W'(k)),
      .probe_i  (probe[k]),
      .commit_i (commit),
      .probe_o  (probe[k+1])
    );
  end

  assign tail     = probe[TABLE_ENTRIES];
  assign new_load = sat_inc(tail.best_load);

  always_comb begin
    commit          = '0;
    commit.op       = tail.cmd;
    commit.id       = tail.id;
    commit.srv_type = tail.srv_type;
    commit.load     = tail.load;
    commit.sock     = tail.sock;
    if (tail.cmd == CMD_UPDATE) begin
      commit.en  = tail.active && !tail.hit && tail.free_ok;
      commit.idx = tail.free_idx;
    end else begin
      commit.en  = tail.active && tail.best_ok;
      commit.idx = tail.best_idx;
    end
  end

  always_comb begin
    if (tail.cmd == CMD_UPDATE) begin
      status_d = (tail.hit || tail.free_ok) ? STATUS_OK : STATUS_FULL;
    end else begin
      status_d = tail.best_ok ? STATUS_OK : STATUS_NO_MATCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
      id_q     <= '0;
      type_q   <= '0;
      load_q   <= '0;
      sock_q   <= '0;
    end else begin
      done_q <= tail.active;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (tail.active) begin
        busy_q <= 1'b0;
      end
      if (tail.active) begin
        status_q <= status_d;
        if ((tail.cmd == CMD_SELECT) && tail.best_ok) begin
          id_q   <= tail.best_id;
          type_q <= tail.best_type;
          load_q <= new_load;
          sock_q <= tail.best_sock;
        end else begin
          id_q   <= '0;
          type_q <= '0;
          load_q <= '0;
          sock_q <= '0;
        end
      end
    end
  end

  assign busy_o          = busy_q;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign chosen_id_o     = id_q;
  assign chosen_type_o   = type_q;
  assign chosen_load_o   = load_q;
  assign chosen_socket_o = sock_q;

endmodule

`default_nettype wire

[sv/llsp_checker.sv]
`default_nettype none

module llsp_checker
  import llsp_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire logic              busy_o,
  input wire logic              done_o,
  input wire logic [1:0]        status_o,
  input wire logic [ID_W-1:0]   chosen_id_o,
  input wire logic [TYPE_W-1:0] chosen_type_o,
  input wire logic [LOAD_W-1:0] chosen_load_o,
  input wire logic [SOCK_W-1:0] chosen_socket_o
);

  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after item accepted");

  // a result only ends a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_o) && !busy_o))
    else $error("result without a pending item");

  // one result per item
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // failed items carry no entry
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STATUS_OK)) |->
      ((chosen_id_o == '0) && (chosen_type_o == '0) &&
       (chosen_load_o == '0) && (chosen_socket_o == '0)))
    else $error("nonzero entry fields on failed item");

endmodule

bind least_loaded_server_picker_core llsp_checker u_llsp_checker (.*);

`default_nettype wire

[verif/least_loaded_server_picker_core_test.sv]
module least_loaded_server_picker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import llsp_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1300;

  typedef struct packed {
    cmd_e              cmd;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] srv_type;
    logic [LOAD_W-1:0] load;
    logic [SOCK_W-1:0] sock;
    logic [TYPE_W-1:0] want;
  } pick_req_t;

  typedef struct packed {
    status_e           status;
    logic [ID_W-1:0]   id;
    logic [TYPE_W-1:0] srv_type;
    logic [LOAD_W-1:0] load;
    logic [SOCK_W-1:0] sock;
  } pick_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              command_i = 1'b0;
  logic [ID_W-1:0]   server_id_i = '0;
  logic [TYPE_W-1:0] server_type_i = '0;
  logic [LOAD_W-1:0] load_count_i = '0;
  logic [SOCK_W-1:0] socket_number_i = '0;
  logic [TYPE_W-1:0] wanted_type_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [1:0]        status_o;
  logic [ID_W-1:0]   chosen_id_o;
  logic [TYPE_W-1:0] chosen_type_o;
  logic [LOAD_W-1:0] chosen_load_o;
  logic [SOCK_W-1:0] chosen_socket_o;

  least_loaded_server_picker_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .command_i       (command_i),
    .server_id_i     (server_id_i),
    .server_type_i   (server_type_i),
    .load_count_i    (load_count_i),
    .socket_number_i (socket_number_i),
    .wanted_type_i   (wanted_type_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .chosen_id_o     (chosen_id_o),
    .chosen_type_o   (chosen_type_o),
    .chosen_load_o   (chosen_load_o),
    .chosen_socket_o (chosen_socket_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // shadow server table
  bit              srv_valid [TABLE_ENTRIES];
  bit [ID_W-1:0]   srv_id    [TABLE_ENTRIES];
  bit [TYPE_W-1:0] srv_type  [TABLE_ENTRIES];
  bit [LOAD_W-1:0] srv_load  [TABLE_ENTRIES];
  bit [SOCK_W-1:0] srv_sock  [TABLE_ENTRIES];

  pick_req_t       pending_q [$];
  pick_res_t       expected_q [$];
  logic [ID_W-1:0] known_ids [$];
  pick_req_t       cur_req;
  pick_res_t       exp_res;
  int              total_items;
  int              issued;
  int              idle_pct;
  int              mismatches;
  int              stall_cycles;
  bit              send_slot;

  function automatic pick_res_t predict_pick(pick_req_t r);
    pick_res_t res;
    int hit_slot;
    int free_slot;
    int best;
    res = '0;
    res.status = STATUS_OK;
    if (r.cmd == CMD_UPDATE) begin
      hit_slot = -1;
      free_slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (srv_valid[i] && srv_id[i] == r.id) hit_slot = i;
        if (!srv_valid[i] && free_slot < 0) free_slot = i;
      end
      if (hit_slot >= 0) begin
        srv_load[hit_slot] = r.load;
        srv_sock[hit_slot] = r.sock;
      end else if (free_slot < 0) begin
        res.status = STATUS_FULL;
      end else begin
        srv_valid[free_slot] = 1'b1;
        srv_id[free_slot] = r.id;
        srv_type[free_slot] = r.srv_type;
        srv_load[free_slot] = r.load;
        srv_sock[free_slot] = r.sock;
      end
    end else begin
      best = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (srv_valid[i] && (srv_type[i] & r.want) != '0) begin
          if (best < 0 || srv_load[i] < srv_load[best] ||
              (srv_load[i] == srv_load[best] && srv_id[i] < srv_id[best])) begin
            best = i;
          end
        end
      end
      if (best < 0) begin
        res.status = STATUS_NO_MATCH;
      end else begin
        // load sticks at its maximum
        if (srv_load[best] != '1) srv_load[best] = srv_load[best] + 1'b1;
        res.id = srv_id[best];
        res.srv_type = srv_type[best];
        res.load = srv_load[best];
        res.sock = srv_sock[best];
      end
    end
    return res;
  endfunction

  function automatic void add_update(logic [ID_W-1:0] id, logic [TYPE_W-1:0] t,
                                     logic [LOAD_W-1:0] ld, logic [SOCK_W-1:0] sk);
    pick_req_t r;
    r.cmd = CMD_UPDATE;
    r.id = id;
    r.srv_type = t;
    r.load = ld;
    r.sock = sk;
    r.want = TYPE_W'($urandom);
    pending_q.push_back(r);
  endfunction

  function automatic void add_select(logic [TYPE_W-1:0] want);
    pick_req_t r;
    r.cmd = CMD_SELECT;
    r.id = ID_W'($urandom);
    r.srv_type = TYPE_W'($urandom);
    r.load = LOAD_W'($urandom);
    r.sock = SOCK_W'($urandom);
    r.want = want;
    pending_q.push_back(r);
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] id;
    bit seen;
    do begin
      id = ID_W'($urandom);
      seen = 1'b0;
      foreach (known_ids[k]) if (known_ids[k] == id) seen = 1'b1;
    end while (seen);
    return id;
  endfunction

  // mostly small loads so ties and minimum races happen often
  function automatic logic [LOAD_W-1:0] rand_load();
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return LOAD_W'($urandom_range(3));
    if (pick < 7) return LOAD_W'(16'hFFFC + $urandom_range(3));
    return LOAD_W'($urandom);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      mismatches++;
      $error("%s: expected %0h, got %0h", name, exp, act);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      send_slot = !start_i;
      if (start_i && !busy_o) begin
        expected_q.push_back(predict_pick(cur_req));
        send_slot = 1'b1;
      end
      if (send_slot) begin
        idle_pct = (issued < total_items / 3) ? 12 :
                   (issued < 2 * total_items / 3) ? 63 : 0;
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_req = pending_q.pop_front();
          issued++;
          start_i <= 1'b1;
          command_i <= cur_req.cmd;
          server_id_i <= cur_req.id;
          server_type_i <= cur_req.srv_type;
          load_count_i <= cur_req.load;
          socket_number_i <= cur_req.sock;
          wanted_type_i <= cur_req.want;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (done_o) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $error("result with no item outstanding");
        end else begin
          exp_res = expected_q.pop_front();
          check_field("status", 32'(exp_res.status), 32'(status_o));
          check_field("chosen_id", 32'(exp_res.id), 32'(chosen_id_o));
          check_field("chosen_type", 32'(exp_res.srv_type), 32'(chosen_type_o));
          check_field("chosen_load", 32'(exp_res.load), 32'(chosen_load_o));
          check_field("chosen_socket", 32'(exp_res.sock), 32'(chosen_socket_o));
        end
      end
    end
  end

  initial begin
    int pick;
    int sub;
    logic [TYPE_W-1:0] want;

    // empty table, then two servers at the id extremes
    add_select(16'hFFFF);
    add_update(16'h0000, 16'h0001, 16'hFFFE, 32'h0000_0000);
    add_update(16'hFFFF, 16'h8000, 16'hFFFE, 32'hFFFF_FFFF);
    known_ids.push_back(16'h0000);
    known_ids.push_back(16'hFFFF);
    // no shared type bit, then an empty mask
    add_select(16'h0100);
    add_select(16'h0000);
    // equal loads go to the lower id, then the load saturates
    add_select(16'h8001);
    add_select(16'h0001);
    // known id keeps its type
    add_update(16'hFFFF, 16'h7FFF, 16'h0000, 32'h5A5A_A5A5);
    add_select(16'h8000);
    // fill the table and overflow it
    for (int i = 0; i < TABLE_ENTRIES - 2; i++) begin
      known_ids.push_back(fresh_id());
      add_update(known_ids[known_ids.size() - 1], TYPE_W'($urandom), rand_load(),
                 SOCK_W'($urandom));
    end
    add_update(fresh_id(), TYPE_W'($urandom), rand_load(), SOCK_W'($urandom));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(19);
      if (pick < 9) begin
        sub = $urandom_range(7);
        if (sub == 0) want = '0;
        else if (sub == 1) want = TYPE_W'(1) << $urandom_range(TYPE_W - 1);
        else if (sub == 2) want = '1;
        else want = TYPE_W'($urandom);
        add_select(want);
      end else if (pick < 17) begin
        add_update(known_ids[$urandom_range(known_ids.size() - 1)], TYPE_W'($urandom),
                   rand_load(), SOCK_W'($urandom));
      end else begin
        add_update(fresh_id(), TYPE_W'($urandom), rand_load(), SOCK_W'($urandom));
      end
    end
    total_items = pending_q.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_q.size() == 0 && !start_i && expected_q.size() == 0) &&
           stall_cycles < STALL_LIMIT) begin
      @(negedge clk_i);
    end
    if (stall_cycles < STALL_LIMIT) repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (stall_cycles >= STALL_LIMIT || mismatches != 0 || expected_q.size() != 0) begin
      $display("least_loaded_server_picker_core_test NOT OK");
    end else begin
      $display("least_loaded_server_picker_core_test OK");
    end
    $finish;
  end

endmodule

[sim.f]
sv/llsp_pkg.sv
sv/llsp_cell.sv
sv/least_loaded_server_picker_core.sv
sv/llsp_checker.sv
verif/least_loaded_server_picker_core_test.sv
